>>> hw/rtl/hsvi_pkg.sv
package hsvi_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned HUE_W    = 15;
  localparam int unsigned QUO_W    = 12;
  localparam int unsigned REM_W    = 20;
  localparam int unsigned DIV_STEPS  = 4;
  localparam int unsigned DIV_STAGES = QUO_W / DIV_STEPS;

  // Hue sector, chosen by which channel is the minimum.
  localparam logic [1:0] SEC_GRAY = 2'd0;
  localparam logic [1:0] SEC_B    = 2'd1;
  localparam logic [1:0] SEC_R    = 2'd2;
  localparam logic [1:0] SEC_G    = 2'd3;

  // Sector base hues in 1/64 degree: 60, 180 and 300 degrees.
  localparam logic [HUE_W-1:0] BASE_B = 15'd3840;
  localparam logic [HUE_W-1:0] BASE_R = 15'd11520;
  localparam logic [HUE_W-1:0] BASE_G = 15'd19200;
  localparam logic [HUE_W-1:0] HALF_TURN_Q = 15'd11520;
  localparam logic [HUE_W:0]   FULL_TURN_Q = 16'd23040;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [CHAN_W-1:0] dlt;
    logic [QUO_W-1:0]  quo;
    logic              neg;
    logic [1:0]        sect;
    logic [CHAN_W-1:0] mx;
    logic [CHAN_W-1:0] bo;
    logic [CHAN_W-1:0] go;
    logic [CHAN_W-1:0] ro;
  } hsvi_div_t;

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [CHAN_W-1:0] sat;
    logic [CHAN_W-1:0] val;
    logic [HUE_W-1:0]  inv;
    logic [CHAN_W-1:0] bo;
    logic [CHAN_W-1:0] go;
    logic [CHAN_W-1:0] ro;
  } hsvi_res_t;

endpackage

>>> hw/rtl/hsvi_front.sv
module hsvi_front import hsvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  logic [CHAN_W-1:0] b_i,
  input  logic [CHAN_W-1:0] g_i,
  input  logic [CHAN_W-1:0] r_i,
  output logic              dn_valid,
  input  logic              dn_ready,
  output hsvi_div_t         dn_data
);

  logic              v_r;
  hsvi_div_t         d_r;
  hsvi_div_t         d_nxt;
  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] dlt;
  logic [CHAN_W:0]   num;
  logic [CHAN_W:0]   sum;
  logic [CHAN_W-1:0] mag;

  always_comb begin
    mx  = (b_i > g_i) ? b_i : g_i;
    mx  = (mx > r_i) ? mx : r_i;
    mn  = (b_i < g_i) ? b_i : g_i;
    mn  = (mn < r_i) ? mn : r_i;
    dlt = mx - mn;
    sum = {1'b0, mx} + {1'b0, mn};

    d_nxt = '0;
    if (mn == b_i) begin
      d_nxt.sect = SEC_B;
      num = {1'b0, g_i} - {1'b0, r_i};
    end else if (mn == r_i) begin
      d_nxt.sect = SEC_R;
      num = {1'b0, b_i} - {1'b0, g_i};
    end else begin
      d_nxt.sect = SEC_G;
      num = {1'b0, r_i} - {1'b0, b_i};
    end
    if (dlt == '0) begin
      d_nxt.sect = SEC_GRAY;
    end
    d_nxt.neg = num[CHAN_W];
    mag = num[CHAN_W] ? CHAN_W'(-num) : num[CHAN_W-1:0];
    // 3840 * mag, as 4096 * mag - 256 * mag.
    d_nxt.rem = (REM_W'(mag) << 12) - (REM_W'(mag) << 8);
    d_nxt.dlt = dlt;
    d_nxt.quo = '0;
    d_nxt.mx  = mx;
    d_nxt.bo  = CHAN_W'(sum - {1'b0, b_i});
    d_nxt.go  = CHAN_W'(sum - {1'b0, g_i});
    d_nxt.ro  = CHAN_W'(sum - {1'b0, r_i});
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/hsvi_div_stage.sv
module hsvi_div_stage import hsvi_pkg::*; #(
  parameter int unsigned LSB = 0
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  hsvi_div_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output hsvi_div_t dn_data
);

  logic             v_r;
  hsvi_div_t        d_r;
  hsvi_div_t        d_nxt;
  logic [REM_W-1:0] trial;

  // Restoring division, DIV_STEPS quotient bits per stage, high bits first.
  always_comb begin
    d_nxt = up_data;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial = REM_W'(up_data.dlt) << (LSB + DIV_STEPS - 1 - k);
      if (d_nxt.rem >= trial) begin
        d_nxt.rem = d_nxt.rem - trial;
        d_nxt.quo[LSB + DIV_STEPS - 1 - k] = 1'b1;
      end
    end
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/hsvi_back.sv
module hsvi_back import hsvi_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      up_valid,
  output logic      up_ready,
  input  hsvi_div_t up_data,
  output logic      dn_valid,
  input  logic      dn_ready,
  output hsvi_res_t dn_data
);

  logic             v_r;
  hsvi_res_t        d_r;
  hsvi_res_t        d_nxt;
  logic [HUE_W-1:0] base;
  logic [QUO_W:0]   qa;
  logic [HUE_W:0]   hue_s;
  logic [HUE_W:0]   inv_s;

  always_comb begin
    case (up_data.sect)
      SEC_B:   base = BASE_B;
      SEC_R:   base = BASE_R;
      SEC_G:   base = BASE_G;
      default: base = '0;
    endcase
    // A negative quotient with a remainder rounds one further down.
    qa = {1'b0, up_data.quo}
         + (QUO_W+1)'(up_data.neg && (up_data.rem != '0));
    if (up_data.sect == SEC_GRAY) begin
      hue_s = '0;
    end else if (up_data.neg) begin
      hue_s = {1'b0, base} - (HUE_W+1)'(qa);
    end else begin
      hue_s = {1'b0, base} + (HUE_W+1)'(qa);
    end
    if (hue_s >= FULL_TURN_Q) begin
      hue_s = hue_s - FULL_TURN_Q;
    end
    inv_s = hue_s + {1'b0, HALF_TURN_Q};
    if (inv_s >= FULL_TURN_Q) begin
      inv_s = inv_s - FULL_TURN_Q;
    end
    d_nxt.hue = hue_s[HUE_W-1:0];
    d_nxt.inv = inv_s[HUE_W-1:0];
    d_nxt.sat = up_data.dlt;
    d_nxt.val = up_data.mx;
    d_nxt.bo  = up_data.bo;
    d_nxt.go  = up_data.go;
    d_nxt.ro  = up_data.ro;
  end

  assign up_ready = !v_r || dn_ready;
  assign dn_valid = v_r;
  assign dn_data  = d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (up_ready) begin
      v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      d_r <= d_nxt;
    end
  end

endmodule

>>> hw/rtl/rgb_hsv_hue_inversion.sv
// Converts one 8-bit BGR pixel per item to hue (1/64 degree), saturation and
// value, turns the hue by 180 degrees and returns the hue-inverted pixel,
// computed exactly as max + min - channel. The block accepts one item every
// clock unless the output stalls, and registers each result in its stages: one
// stage finds max, min and the hue numerator, three stages run a pipelined
// restoring divider at four quotient bits each, and the last stage applies
// floor rounding, the sector offset and the half-turn. A stall on the output
// holds the pipeline; empty stages still fill while it waits.
module rgb_hsv_hue_inversion import hsvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] in_blue_in,
  input  logic [CHAN_W-1:0] in_green_in,
  input  logic [CHAN_W-1:0] in_red_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HUE_W-1:0]  out_hue_q,
  output logic [CHAN_W-1:0] out_saturation,
  output logic [CHAN_W-1:0] out_brightness,
  output logic [HUE_W-1:0]  out_inverted_hue_q,
  output logic [CHAN_W-1:0] out_blue_out,
  output logic [CHAN_W-1:0] out_green_out,
  output logic [CHAN_W-1:0] out_red_out
);

  logic      s_valid [DIV_STAGES+1];
  logic      s_ready [DIV_STAGES+1];
  hsvi_div_t s_data  [DIV_STAGES+1];
  hsvi_res_t res;

  hsvi_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .b_i      (in_blue_in),
    .g_i      (in_green_in),
    .r_i      (in_red_in),
    .dn_valid (s_valid[0]),
    .dn_ready (s_ready[0]),
    .dn_data  (s_data[0])
  );

  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    hsvi_div_stage #(
      .LSB ((DIV_STAGES - 1 - i) * DIV_STEPS)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (s_valid[i]),
      .up_ready (s_ready[i]),
      .up_data  (s_data[i]),
      .dn_valid (s_valid[i+1]),
      .dn_ready (s_ready[i+1]),
      .dn_data  (s_data[i+1])
    );
  end

  hsvi_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (s_valid[DIV_STAGES]),
    .up_ready (s_ready[DIV_STAGES]),
    .up_data  (s_data[DIV_STAGES]),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_data  (res)
  );

  assign out_hue_q          = res.hue;
  assign out_saturation     = res.sat;
  assign out_brightness     = res.val;
  assign out_inverted_hue_q = res.inv;
  assign out_blue_out       = res.bo;
  assign out_green_out      = res.go;
  assign out_red_out        = res.ro;

`ifndef SYNTHESIS
  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_hue_q} < FULL_TURN_Q))
    else $error("hue out of range");

  a_inv_half_turn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (({1'b0, out_inverted_hue_q} == {1'b0, out_hue_q} + 16'd11520) ||
                   ({1'b0, out_inverted_hue_q} + 16'd11520 == {1'b0, out_hue_q})))
    else $error("inverted hue is not a half turn away");

  a_gray: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_saturation == '0) |->
      (out_hue_q == '0 && out_blue_out == out_brightness &&
       out_green_out == out_brightness && out_red_out == out_brightness))
    else $error("gray item gave nonzero hue or changed pixel");

  a_pixel_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_blue_out <= out_brightness && out_green_out <= out_brightness &&
                   out_red_out <= out_brightness))
    else $error("output channel above brightness");
`endif

endmodule

>>> verif/hsvi_result_monitor.sv
module hsvi_result_monitor import hsvi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [CHAN_W-1:0] in_blue_in,
  input  logic [CHAN_W-1:0] in_green_in,
  input  logic [CHAN_W-1:0] in_red_in,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [HUE_W-1:0]  out_hue_q,
  input  logic [CHAN_W-1:0] out_saturation,
  input  logic [CHAN_W-1:0] out_brightness,
  input  logic [HUE_W-1:0]  out_inverted_hue_q,
  input  logic [CHAN_W-1:0] out_blue_out,
  input  logic [CHAN_W-1:0] out_green_out,
  input  logic [CHAN_W-1:0] out_red_out,
  output int                pending,
  output int                fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEG_Q       = 64;
  localparam int SIXTY_DEG_Q = 3840;
  localparam int HALF_TURN   = 11520;
  localparam int FULL_TURN   = 23040;

  hsvi_res_t expected_pixels[$];

  function automatic hsvi_res_t invert_hue_pixel(input logic [CHAN_W-1:0] b,
                                                 input logic [CHAN_W-1:0] g,
                                                 input logic [CHAN_W-1:0] r);
    hsvi_res_t res;
    int mx, mn, dlt, num, sector_deg, prod, quo, hue, inv;
    mx = b;
    if (g > mx) mx = g;
    if (r > mx) mx = r;
    mn = b;
    if (g < mn) mn = g;
    if (r < mn) mn = r;
    dlt = mx - mn;
    hue = 0;
    if (dlt != 0) begin
      // The minimum is tested blue first, then red, so ties fall that way.
      if (mn == b) begin
        sector_deg = 60;
        num = int'(g) - int'(r);
      end else if (mn == r) begin
        sector_deg = 180;
        num = int'(b) - int'(g);
      end else begin
        sector_deg = 300;
        num = int'(r) - int'(b);
      end
      prod = SIXTY_DEG_Q * num;
      quo = prod / dlt;
      // Integer division truncates toward zero; the hue wants floor.
      if ((prod % dlt) != 0 && prod < 0) quo = quo - 1;
      hue = sector_deg * DEG_Q + quo;
    end
    hue = hue % FULL_TURN;
    inv = (hue + HALF_TURN) % FULL_TURN;
    res.hue = hue[HUE_W-1:0];
    res.sat = dlt[CHAN_W-1:0];
    res.val = mx[CHAN_W-1:0];
    res.inv = inv[HUE_W-1:0];
    res.bo  = CHAN_W'(mx + mn - int'(b));
    res.go  = CHAN_W'(mx + mn - int'(g));
    res.ro  = CHAN_W'(mx + mn - int'(r));
    return res;
  endfunction

  hsvi_res_t exp_px;
  hsvi_res_t act_px;

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        act_px.hue = out_hue_q;
        act_px.sat = out_saturation;
        act_px.val = out_brightness;
        act_px.inv = out_inverted_hue_q;
        act_px.bo  = out_blue_out;
        act_px.go  = out_green_out;
        act_px.ro  = out_red_out;
        if (expected_pixels.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: unexpected result item hue %0d", $realtime, out_hue_q);
          fail_count = fail_count + 1;
        end else begin
          exp_px = expected_pixels.pop_front();
          if (act_px.hue != exp_px.hue || act_px.sat != exp_px.sat ||
              act_px.val != exp_px.val || act_px.inv != exp_px.inv ||
              act_px.bo != exp_px.bo || act_px.go != exp_px.go ||
              act_px.ro != exp_px.ro) begin
            if (fail_count < 10) begin
              $display("%0t: mismatch hue %0d/%0d sat %0d/%0d val %0d/%0d inv %0d/%0d",
                       $realtime, exp_px.hue, act_px.hue, exp_px.sat, act_px.sat,
                       exp_px.val, act_px.val, exp_px.inv, act_px.inv);
              $display("  bgr out expected %0d %0d %0d, got %0d %0d %0d",
                       exp_px.bo, exp_px.go, exp_px.ro, act_px.bo, act_px.go, act_px.ro);
            end
            fail_count = fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready)
        expected_pixels.push_back(invert_hue_pixel(in_blue_in, in_green_in, in_red_in));
    end
    pending = expected_pixels.size();
  end

endmodule

>>> verif/testbench.sv
module testbench;
  import hsvi_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1950;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DIRECTED_CNT = 24;

  // Directed pixels, packed as {blue, green, red}.
  localparam logic [23:0] DIRECTED_BGR [DIRECTED_CNT] = '{
    24'h000000, 24'hFFFFFF, 24'h808080, 24'h0000FF, 24'h00FF00, 24'hFF0000,
    24'h00FFFF, 24'hFFFF00, 24'hFF00FF, 24'h0AC80A, 24'hC80A0A, 24'h0505FA,
    24'h0064FF, 24'hFE00FF, 24'h010000, 24'h000100, 24'h000001, 24'h25C963,
    24'h7F8081, 24'h807F80, 24'h01FEFF, 24'hFFFE01, 24'hAA55AA, 24'h55AA55
  };

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [CHAN_W-1:0] in_blue_in = '0;
  logic [CHAN_W-1:0] in_green_in = '0;
  logic [CHAN_W-1:0] in_red_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [HUE_W-1:0]  out_hue_q;
  logic [CHAN_W-1:0] out_saturation;
  logic [CHAN_W-1:0] out_brightness;
  logic [HUE_W-1:0]  out_inverted_hue_q;
  logic [CHAN_W-1:0] out_blue_out;
  logic [CHAN_W-1:0] out_green_out;
  logic [CHAN_W-1:0] out_red_out;

  int pending;
  int fail_count;
  int cycles = 0;
  int ready_left = 0;
  bit no_idle = 1'b0;
  bit ready_pick;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rgb_hsv_hue_inversion i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_blue_in         (in_blue_in),
    .in_green_in        (in_green_in),
    .in_red_in          (in_red_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hue_q          (out_hue_q),
    .out_saturation     (out_saturation),
    .out_brightness     (out_brightness),
    .out_inverted_hue_q (out_inverted_hue_q),
    .out_blue_out       (out_blue_out),
    .out_green_out      (out_green_out),
    .out_red_out        (out_red_out)
  );

  hsvi_result_monitor i_monitor (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_blue_in         (in_blue_in),
    .in_green_in        (in_green_in),
    .in_red_in          (in_red_in),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_hue_q          (out_hue_q),
    .out_saturation     (out_saturation),
    .out_brightness     (out_brightness),
    .out_inverted_hue_q (out_inverted_hue_q),
    .out_blue_out       (out_blue_out),
    .out_green_out      (out_green_out),
    .out_red_out        (out_red_out),
    .pending            (pending),
    .fail_count         (fail_count)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (no_idle || p < 55) return 0;
    if (p < 88) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (ready_left > 0) begin
      ready_left = ready_left - 1;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else begin
      ready_pick = $urandom_range(0, 2) != 0;
      out_ready <= ready_pick;
      ready_left = ready_pick ? $urandom_range(0, 10) : pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                            input logic [CHAN_W-1:0] r);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_blue_in  <= b;
    in_green_in <= g;
    in_red_in   <= r;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic draw_pixel(output logic [CHAN_W-1:0] b, output logic [CHAN_W-1:0] g,
                            output logic [CHAN_W-1:0] r);
    int kind;
    int base;
    kind = $urandom_range(0, 99);
    b = CHAN_W'($urandom_range(0, 255));
    g = CHAN_W'($urandom_range(0, 255));
    r = CHAN_W'($urandom_range(0, 255));
    if (kind < 8) begin
      g = b;
      r = b;
    end else if (kind < 22) begin
      // Two equal channels exercise the tie order for the minimum.
      case ($urandom_range(0, 2))
        0:       g = b;
        1:       r = g;
        default: r = b;
      endcase
    end else if (kind < 34) begin
      if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end else if (kind < 42) begin
      base = $urandom_range(0, 252);
      b = CHAN_W'(base + int'($urandom_range(0, 3)));
      g = CHAN_W'(base + int'($urandom_range(0, 3)));
      r = CHAN_W'(base + int'($urandom_range(0, 3)));
    end
  endtask

  initial begin
    logic [CHAN_W-1:0] b, g, r;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED_BGR[i])
      send_pixel(DIRECTED_BGR[i][23:16], DIRECTED_BGR[i][15:8], DIRECTED_BGR[i][7:0]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      no_idle = (n >= 300 && n < 500) || (n >= 1100 && n < 1250);
      if (n == 700 || n == 1400) wait_drained();
      draw_pixel(b, g, r);
      send_pixel(b, g, r);
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (20) @(negedge clk);
    if (fail_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule
